// ===== rtl/core/dirty_tile_tracker_assert.svh =====
// Assertion macros used by the dirty tile tracker checker.
`ifndef DIRTY_TILE_TRACKER_ASSERT_SVH
`define DIRTY_TILE_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define DTT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dirty_tile_tracker assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define DTT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dirty_tile_tracker assertion failed");

`endif

// ===== rtl/core/dtt_pkg.sv =====
// Constants and types of the dirty tile tracker.
package dtt_pkg;

	localparam int TILE_PIXELS   = 32;
	localparam int MAX_TILE_COLS = 8;
	localparam int MAX_TILE_ROWS = 8;

	localparam int TILE_SHIFT = $clog2(TILE_PIXELS);
	localparam int GRID_MAX   = (MAX_TILE_COLS > MAX_TILE_ROWS) ? MAX_TILE_COLS : MAX_TILE_ROWS;
	localparam int CNT_W      = $clog2(GRID_MAX + 1);
	localparam int COL_W      = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
	localparam int ROW_W      = (MAX_TILE_ROWS > 1) ? $clog2(MAX_TILE_ROWS) : 1;

	localparam logic CFG_SCREEN_WIDTH  = 1'b0;
	localparam logic CFG_SCREEN_HEIGHT = 1'b1;

	localparam logic OP_MARK  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic                     empty;
		logic [MAX_TILE_COLS-1:0] mask;
		logic [ROW_W-1:0]         y_lo;
		logic [ROW_W-1:0]         y_last;
	} span_t;

endpackage

// ===== rtl/core/dtt_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
module dtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/dtt_span.sv =====
// Turns a mark rectangle into a column mask and a clamped row range.
module dtt_span (
	input  logic signed [15:0]        rect_x,
	input  logic signed [15:0]        rect_y,
	input  logic signed [15:0]        rect_w,
	input  logic signed [15:0]        rect_h,
	input  logic [dtt_pkg::CNT_W-1:0] cols_n,
	input  logic [dtt_pkg::CNT_W-1:0] rows_n,
	output dtt_pkg::span_t            span
);
	import dtt_pkg::*;

	typedef struct packed {
		logic             empty;
		logic [CNT_W-1:0] lo;
		logic [CNT_W-1:0] last;
	} axis_t;

	function automatic axis_t axis_range(input logic signed [15:0] pos,
			input logic signed [15:0] ext, input logic [CNT_W-1:0] cnt);
		logic signed [17:0] sum;
		logic [15:0]        lo_full;
		logic [16:0]        hi_full;
		logic [CNT_W-1:0]   hi;
		axis_t              r;
		lo_full = pos[15] ? '0 : (unsigned'(pos) >> TILE_SHIFT);
		sum = 18'(pos) + 18'(ext) + 18'(TILE_PIXELS - 1);
		hi_full = (sum <= 0) ? '0 : (sum[16:0] >> TILE_SHIFT);
		hi = (hi_full > 17'(cnt)) ? cnt : hi_full[CNT_W-1:0];
		r.empty = (lo_full >= 16'(hi));
		r.lo = lo_full[CNT_W-1:0];
		r.last = hi - CNT_W'(1);
		return r;
	endfunction

	axis_t xa;
	axis_t ya;

	always_comb begin
		xa = axis_range(rect_x, rect_w, cols_n);
		ya = axis_range(rect_y, rect_h, rows_n);
		span.empty = xa.empty || ya.empty;
		for (int c = 0; c < MAX_TILE_COLS; c++) begin
			span.mask[c] = (CNT_W'(c) >= xa.lo) && (CNT_W'(c) <= xa.last);
		end
		span.y_lo = ROW_W'(ya.lo);
		span.y_last = ROW_W'(ya.last);
	end

endmodule

// ===== rtl/core/dirty_tile_tracker.sv =====
// Top level of the dirty tile tracker: control sequencer around the tile map memory.
// A mark reads and writes back each touched tile row (MREAD, MWRITE) and stays idle when
// it touches nothing; a flush reads each grid row (FREAD, FLOAD), scans its tiles in
// FSCAN and ends in FDONE, because the map is one memory row of tile bits per tile row
// and every update is a read, modify and write of one row. Results of a flush come one
// per dirty tile, each on the result ports for a single cycle with result_valid high,
// and the final one, marked by last_tile, comes in the first cycle with busy low. The
// receiver cannot stall the block. Reset clears the map at once through row valid bits,
// so no clearing pass is needed and the block takes an item right after reset.
module dirty_tile_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [8:0]         cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic signed [15:0] rect_x,
	input  logic signed [15:0] rect_y,
	input  logic signed [15:0] rect_w,
	input  logic signed [15:0] rect_h,
	output logic               result_valid,
	output logic [2:0]         tile_col,
	output logic [2:0]         tile_row,
	output logic [7:0]         x_start,
	output logic [8:0]         x_end,
	output logic [7:0]         y_start,
	output logic [8:0]         y_end,
	output logic               none_dirty,
	output logic               last_tile
);
	import dtt_pkg::*;

	localparam int XW = COL_W + TILE_SHIFT + 1;
	localparam int YW = ROW_W + TILE_SHIFT + 1;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_MREAD  = 7'b0000010,
		S_MWRITE = 7'b0000100,
		S_FREAD  = 7'b0001000,
		S_FLOAD  = 7'b0010000,
		S_FSCAN  = 7'b0100000,
		S_FDONE  = 7'b1000000
	} state_t;

	state_t                   state_q;
	logic [8:0]               width_q;
	logic [8:0]               height_q;
	logic [ROW_W-1:0]         row_q;
	logic [COL_W-1:0]         col_q;
	span_t                    span_q;
	logic [MAX_TILE_ROWS-1:0] row_vld_q;
	logic [MAX_TILE_COLS-1:0] row_bits_q;
	logic                     pend_vld_q;
	logic [COL_W-1:0]         pend_col_q;
	logic [ROW_W-1:0]         pend_row_q;

	logic                     res_vld_q;
	logic [2:0]               tile_col_q;
	logic [2:0]               tile_row_q;
	logic [7:0]               x_start_q;
	logic [8:0]               x_end_q;
	logic [7:0]               y_start_q;
	logic [8:0]               y_end_q;
	logic                     none_q;
	logic                     last_q;

	logic [9:0]               cols_full;
	logic [9:0]               rows_full;
	logic [CNT_W-1:0]         cols_n;
	logic [CNT_W-1:0]         rows_n;
	span_t                    span;
	logic                     accept;
	logic                     ram_we;
	logic [MAX_TILE_COLS-1:0] ram_wdata;
	logic [MAX_TILE_COLS-1:0] ram_rdata;
	logic [MAX_TILE_COLS-1:0] row_cur;
	logic                     hit;
	logic                     col_end;
	logic                     row_end;

	logic                     emit;
	logic                     emit_none;
	logic                     emit_last;
	logic [COL_W-1:0]         emit_col;
	logic [ROW_W-1:0]         emit_row;
	logic [XW-2:0]            xs_full;
	logic [YW-2:0]            ys_full;
	logic [XW-1:0]            xe_full;
	logic [YW-1:0]            ye_full;
	logic [9:0]               xe_w;
	logic [9:0]               ye_w;

	assign cols_full = ({1'b0, width_q} + 10'(TILE_PIXELS - 1)) >> TILE_SHIFT;
	assign rows_full = ({1'b0, height_q} + 10'(TILE_PIXELS - 1)) >> TILE_SHIFT;
	assign cols_n = (cols_full > 10'(MAX_TILE_COLS)) ? CNT_W'(MAX_TILE_COLS)
	                                                 : cols_full[CNT_W-1:0];
	assign rows_n = (rows_full > 10'(MAX_TILE_ROWS)) ? CNT_W'(MAX_TILE_ROWS)
	                                                 : rows_full[CNT_W-1:0];

	dtt_span u_span (
		.rect_x (rect_x),
		.rect_y (rect_y),
		.rect_w (rect_w),
		.rect_h (rect_h),
		.cols_n (cols_n),
		.rows_n (rows_n),
		.span   (span)
	);

	assign row_cur = row_vld_q[row_q] ? ram_rdata : '0;
	assign ram_we = (state_q == S_MWRITE);
	assign ram_wdata = row_cur | span_q.mask;

	dtt_ram #(
		.WIDTH (MAX_TILE_COLS),
		.DEPTH (MAX_TILE_ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (row_q),
		.wdata (ram_wdata),
		.raddr (row_q),
		.rdata (ram_rdata)
	);

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign hit = (state_q == S_FSCAN) && row_bits_q[col_q];
	assign col_end = (CNT_W'(col_q) == cols_n - CNT_W'(1));
	assign row_end = (CNT_W'(row_q) == rows_n - CNT_W'(1));

	always_comb begin
		emit = 1'b0;
		emit_none = 1'b0;
		emit_last = 1'b0;
		emit_col = pend_col_q;
		emit_row = pend_row_q;
		if (hit && pend_vld_q) begin
			emit = 1'b1;
		end else if (state_q == S_FDONE) begin
			emit = 1'b1;
			emit_last = 1'b1;
			emit_none = !pend_vld_q;
		end
		xs_full = {emit_col, TILE_SHIFT'(0)};
		ys_full = {emit_row, TILE_SHIFT'(0)};
		xe_full = {1'b0, xs_full} + XW'(TILE_PIXELS);
		ye_full = {1'b0, ys_full} + YW'(TILE_PIXELS);
		xe_w = 10'(xe_full);
		ye_w = 10'(ye_full);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_q <= 9'd256;
			height_q <= 9'd256;
			row_vld_q <= '0;
			pend_vld_q <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SCREEN_WIDTH: width_q <= cfg_data;
					CFG_SCREEN_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end
			res_vld_q <= emit;
			if (hit) begin
				pend_vld_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (operation == OP_FLUSH) begin
							pend_vld_q <= 1'b0;
							state_q <= (rows_n == '0 || cols_n == '0) ? S_FDONE : S_FREAD;
						end else if (!span.empty) begin
							state_q <= S_MREAD;
						end
					end
				end
				S_MREAD: state_q <= S_MWRITE;
				S_MWRITE: begin
					row_vld_q[row_q] <= 1'b1;
					state_q <= (row_q == span_q.y_last) ? S_IDLE : S_MREAD;
				end
				S_FREAD: state_q <= S_FLOAD;
				S_FLOAD: state_q <= S_FSCAN;
				S_FSCAN: begin
					if (col_end) begin
						state_q <= row_end ? S_FDONE : S_FREAD;
					end
				end
				S_FDONE: begin
					row_vld_q <= '0;
					pend_vld_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			span_q <= span;
			row_q <= (operation == OP_FLUSH) ? '0 : span.y_lo;
		end
		if (state_q == S_MWRITE || (state_q == S_FSCAN && col_end)) begin
			row_q <= row_q + ROW_W'(1);
		end
		if (state_q == S_FLOAD) begin
			row_bits_q <= row_cur;
			col_q <= '0;
		end
		if (state_q == S_FSCAN) begin
			col_q <= col_q + COL_W'(1);
		end
		if (hit) begin
			pend_col_q <= col_q;
			pend_row_q <= row_q;
		end
		if (emit) begin
			none_q <= emit_none;
			last_q <= emit_last;
			if (emit_none) begin
				tile_col_q <= '0;
				tile_row_q <= '0;
				x_start_q <= '0;
				x_end_q <= '0;
				y_start_q <= '0;
				y_end_q <= '0;
			end else begin
				tile_col_q <= 3'(emit_col);
				tile_row_q <= 3'(emit_row);
				x_start_q <= 8'(xs_full);
				y_start_q <= 8'(ys_full);
				x_end_q <= (xe_w > {1'b0, width_q}) ? width_q : 9'(xe_w);
				y_end_q <= (ye_w > {1'b0, height_q}) ? height_q : 9'(ye_w);
			end
		end
	end

	assign result_valid = res_vld_q;
	assign tile_col = tile_col_q;
	assign tile_row = tile_row_q;
	assign x_start = x_start_q;
	assign x_end = x_end_q;
	assign y_start = y_start_q;
	assign y_end = y_end_q;
	assign none_dirty = none_q;
	assign last_tile = last_q;

endmodule

// ===== rtl/core/dirty_tile_tracker_chk.sv =====
// Port-level checker of the dirty tile tracker and its bind to the top level.
module dirty_tile_tracker_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       operation,
	input logic       result_valid,
	input logic [2:0] tile_col,
	input logic [8:0] x_end,
	input logic       none_dirty,
	input logic       last_tile
);
	import dtt_pkg::*;

`include "dirty_tile_tracker_assert.svh"

	`DTT_ASSERT_NEXT(a_flush_goes_busy, start && !busy && operation == OP_FLUSH, busy)
	`DTT_ASSERT_IMPL(a_none_is_last, result_valid && none_dirty, last_tile)
	`DTT_ASSERT_IMPL(a_none_fields_zero, result_valid && none_dirty, tile_col == 3'd0 && x_end == 9'd0)
	`DTT_ASSERT_IMPL(a_last_after_busy, result_valid && last_tile, !busy && $past(busy))
	`DTT_ASSERT_IMPL(a_inner_while_busy, result_valid && !last_tile, busy)

endmodule

bind dirty_tile_tracker dirty_tile_tracker_chk u_chk (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the dirty tile tracker against a tile map predictor.
module tb_top;
	import dtt_pkg::*;

	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 90;
	localparam int PHASES        = 10;
	localparam int FIXED_PHASES  = 8;
	localparam int PHASE_ITEMS   = 36;

	typedef struct packed {
		logic [2:0] col;
		logic [2:0] row;
		logic [7:0] xs;
		logic [8:0] xe;
		logic [7:0] ys;
		logic [8:0] ye;
		logic       none;
		logic       last;
	} tile_rpt_t;

	typedef struct packed {
		logic               op;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] w;
		logic signed [15:0] h;
		logic               typed;
		tile_rpt_t          rpt;
	} stim_row_t;

	localparam tile_rpt_t RPT_NONE   = '0;
	localparam tile_rpt_t RPT_EMPTY  = '{3'd0, 3'd0, 8'd0, 9'd0, 8'd0, 9'd0, 1'b1, 1'b1};
	localparam tile_rpt_t RPT_ORIGIN = '{3'd0, 3'd0, 8'd0, 9'd32, 8'd0, 9'd32, 1'b0, 1'b1};
	localparam tile_rpt_t RPT_CORNER = '{3'd7, 3'd7, 8'd224, 9'd256, 8'd224, 9'd256, 1'b0, 1'b1};

	localparam stim_row_t DIRECTED [22] = '{
		'{OP_FLUSH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, RPT_EMPTY},
		'{OP_MARK, 16'sd0, 16'sd0, 16'sd1, 16'sd1, 1'b0, RPT_NONE},
		'{OP_FLUSH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, RPT_ORIGIN},
		'{OP_MARK, 16'sd255, 16'sd255, 16'sd1, 16'sd1, 1'b0, RPT_NONE},
		'{OP_FLUSH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, RPT_CORNER},
		'{OP_MARK, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, RPT_NONE},
		'{OP_MARK, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, RPT_NONE},
		'{OP_MARK, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b0, RPT_NONE},
		'{OP_FLUSH, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1, RPT_EMPTY},
		'{OP_MARK, -16'sd31, -16'sd31, 16'sd33, 16'sd33, 1'b0, RPT_NONE},
		'{OP_FLUSH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, RPT_ORIGIN},
		'{OP_MARK, -16'sd31, -16'sd31, 16'sd1, 16'sd1, 1'b0, RPT_NONE},
		'{OP_FLUSH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, RPT_EMPTY},
		'{OP_MARK, -16'sd100, -16'sd100, 16'sd32767, 16'sd32767, 1'b0, RPT_NONE},
		'{OP_FLUSH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, RPT_NONE},
		'{OP_MARK, 16'sd100, 16'sd100, 16'sd0, 16'sd0, 1'b0, RPT_NONE},
		'{OP_MARK, 16'sd50, 16'sd50, -16'sd10, -16'sd10, 1'b0, RPT_NONE},
		'{OP_MARK, 16'sd0, 16'sd224, 16'sd32767, 16'sd1, 1'b0, RPT_NONE},
		'{OP_MARK, 16'sd224, 16'sd0, 16'sd1, 16'sd32767, 1'b0, RPT_NONE},
		'{OP_MARK, 16'sd64, 16'sd96, -16'sd32768, -16'sd32768, 1'b0, RPT_NONE},
		'{OP_FLUSH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, RPT_NONE},
		'{OP_FLUSH, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, RPT_EMPTY}
	};

	localparam logic [8:0] SCR_W_SET [FIXED_PHASES] = '{9'd256, 9'd1, 9'd511, 9'd0,
		9'd256, 9'd100, 9'd33, 9'd255};
	localparam logic [8:0] SCR_H_SET [FIXED_PHASES] = '{9'd256, 9'd1, 9'd511, 9'd256,
		9'd0, 9'd70, 9'd255, 9'd33};

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic               cfg_index = CFG_SCREEN_WIDTH;
	logic [8:0]         cfg_data  = '0;
	logic               start     = 1'b0;
	logic               busy;
	logic               operation = OP_MARK;
	logic signed [15:0] rect_x    = '0;
	logic signed [15:0] rect_y    = '0;
	logic signed [15:0] rect_w    = '0;
	logic signed [15:0] rect_h    = '0;
	logic               result_valid;
	logic [2:0]         tile_col;
	logic [2:0]         tile_row;
	logic [7:0]         x_start;
	logic [8:0]         x_end;
	logic [7:0]         y_start;
	logic [8:0]         y_end;
	logic               none_dirty;
	logic               last_tile;

	logic [8:0] scr_w = 9'd256;
	logic [8:0] scr_h = 9'd256;
	bit         tile_dirty [MAX_TILE_ROWS][MAX_TILE_COLS];
	tile_rpt_t  flush_rpts [$];
	tile_rpt_t  tile_q [$];
	int         fail_cnt    = 0;
	int         idle_cycles = 0;
	int         calm_left   = 0;

	dirty_tile_tracker i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.operation(operation),
		.rect_x(rect_x),
		.rect_y(rect_y),
		.rect_w(rect_w),
		.rect_h(rect_h),
		.result_valid(result_valid),
		.tile_col(tile_col),
		.tile_row(tile_row),
		.x_start(x_start),
		.x_end(x_end),
		.y_start(y_start),
		.y_end(y_end),
		.none_dirty(none_dirty),
		.last_tile(last_tile)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int grid_of(logic [8:0] px, int lim);
		int n;
		n = (int'(px) + TILE_PIXELS - 1) / TILE_PIXELS;
		return (n > lim) ? lim : n;
	endfunction

	function automatic void track_item(logic op, logic signed [15:0] rx, logic signed [15:0] ry,
			logic signed [15:0] rw, logic signed [15:0] rh);
		int cols, rows, tx0, ty0, tx1, ty1, xs, ys, xe, ye;
		tile_rpt_t r;
		cols = grid_of(scr_w, MAX_TILE_COLS);
		rows = grid_of(scr_h, MAX_TILE_ROWS);
		flush_rpts.delete();
		if (op == OP_MARK) begin
			tx0 = int'(rx) / TILE_PIXELS;
			ty0 = int'(ry) / TILE_PIXELS;
			tx1 = (int'(rx) + int'(rw) + TILE_PIXELS - 1) / TILE_PIXELS;
			ty1 = (int'(ry) + int'(rh) + TILE_PIXELS - 1) / TILE_PIXELS;
			if (tx0 < 0) tx0 = 0;
			if (ty0 < 0) ty0 = 0;
			if (tx1 > cols) tx1 = cols;
			if (ty1 > rows) ty1 = rows;
			for (int ty = ty0; ty < ty1; ty++)
				for (int tx = tx0; tx < tx1; tx++)
					tile_dirty[ty][tx] = 1'b1;
		end else begin
			for (int ty = 0; ty < rows; ty++) begin
				for (int tx = 0; tx < cols; tx++) begin
					if (tile_dirty[ty][tx]) begin
						xs = tx * TILE_PIXELS;
						ys = ty * TILE_PIXELS;
						xe = xs + TILE_PIXELS;
						ye = ys + TILE_PIXELS;
						if (xe > int'(scr_w)) xe = int'(scr_w);
						if (ye > int'(scr_h)) ye = int'(scr_h);
						r = '0;
						r.col = 3'(tx);
						r.row = 3'(ty);
						r.xs = 8'(xs);
						r.xe = 9'(xe);
						r.ys = 8'(ys);
						r.ye = 9'(ye);
						flush_rpts.push_back(r);
					end
				end
			end
			foreach (tile_dirty[ty, tx]) tile_dirty[ty][tx] = 1'b0;
			if (flush_rpts.size() == 0)
				flush_rpts.push_back(RPT_EMPTY);
			else
				flush_rpts[flush_rpts.size() - 1].last = 1'b1;
		end
	endfunction

	function automatic int draw_gap();
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm_left = $urandom_range(5, 30);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	function automatic logic signed [15:0] rand_pos();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'(-int'($urandom_range(1, 100)));
			default: return 16'($urandom_range(0, 300));
		endcase
	endfunction

	function automatic logic signed [15:0] rand_span();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return 16'(-int'($urandom_range(0, 64)));
			2: return 16'($urandom_range(200, 600));
			default: return 16'($urandom_range(1, 96));
		endcase
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endfunction

	// The caller must either issue the next item or lower start in the same time step.
	task automatic issue_item(logic op, logic signed [15:0] rx, logic signed [15:0] ry,
			logic signed [15:0] rw, logic signed [15:0] rh, logic typed, tile_rpt_t rpt);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		rect_x    <= rx;
		rect_y    <= ry;
		rect_w    <= rw;
		rect_h    <= rh;
		@(posedge clk);
		while (busy) @(posedge clk);
		track_item(op, rx, ry, rw, rh);
		if (typed)
			tile_q.push_back(rpt);
		else
			foreach (flush_rpts[i]) tile_q.push_back(flush_rpts[i]);
	endtask

	task automatic settle_all();
		start <= 1'b0;
		while (tile_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_screen(logic [8:0] w, logic [8:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SCREEN_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= CFG_SCREEN_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		scr_w = w;
		scr_h = h;
	endtask

	always @(posedge clk) begin
		tile_rpt_t got, want;
		if (arst_n && result_valid) begin
			got = '{tile_col, tile_row, x_start, x_end, y_start, y_end, none_dirty, last_tile};
			if (tile_q.size() == 0) begin
				$error("unexpected tile report: col %0d row %0d", tile_col, tile_row);
				fail_cnt++;
			end else begin
				want = tile_q.pop_front();
				check_field("tile_col", 16'(want.col), 16'(got.col));
				check_field("tile_row", 16'(want.row), 16'(got.row));
				check_field("x_start", 16'(want.xs), 16'(got.xs));
				check_field("x_end", 16'(want.xe), 16'(got.xe));
				check_field("y_start", 16'(want.ys), 16'(got.ys));
				check_field("y_end", 16'(want.ye), 16'(got.ye));
				check_field("none_dirty", 16'(want.none), 16'(got.none));
				check_field("last_tile", 16'(want.last), 16'(got.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic op;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i])
			issue_item(DIRECTED[i].op, DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].w,
				DIRECTED[i].h, DIRECTED[i].typed, DIRECTED[i].rpt);
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				settle_all();
				if (p < FIXED_PHASES)
					write_screen(SCR_W_SET[p], SCR_H_SET[p]);
				else
					write_screen(9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)));
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				op = ($urandom_range(0, 5) == 0) ? OP_FLUSH : OP_MARK;
				issue_item(op, rand_pos(), rand_pos(), rand_span(), rand_span(), 1'b0, RPT_NONE);
				if ($urandom_range(0, 40) == 0) settle_all();
			end
		end
		settle_all();
		if (fail_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dtt_pkg.sv
rtl/core/dtt_ram.sv
rtl/core/dtt_span.sv
rtl/core/dirty_tile_tracker.sv
rtl/core/dirty_tile_tracker_chk.sv
bench/tb_top.sv
